// File: hdl/onc_pkg.sv
// ----------------------------------------------------------------------------
// onc_pkg
// shared constants and types for the nearest centroid clustering core
// ----------------------------------------------------------------------------
package onc_pkg;

  localparam int MAX_CLUSTERS = 64;
  localparam int COORD_BITS   = 16;
  localparam int CNT_BITS     = 16;
  localparam int MD_BITS      = 16;
  localparam int OUT_IDX_W    = 6;
  localparam int IDX_W        = $clog2(MAX_CLUSTERS);
  localparam int USED_W       = $clog2(MAX_CLUSTERS + 1);
  localparam int DIST_W       = (2 * COORD_BITS + 2 > 2 * MD_BITS) ?
                                (2 * COORD_BITS + 2) : (2 * MD_BITS);
  localparam int DIV_W        = ((COORD_BITS > CNT_BITS) ? COORD_BITS : CNT_BITS) + 2;
  localparam int DIV_CW       = $clog2(DIV_W + 1);
  localparam int REQ_DATA_W   = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int RES_RAW_W    = OUT_IDX_W + 3 * COORD_BITS + CNT_BITS;
  localparam int RES_DATA_W   = ((RES_RAW_W + 7) / 8) * 8;

  localparam logic [CNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [MD_BITS-1:0]  MD_RESET   = MD_BITS'(256);

  typedef enum logic [1:0] {
    ST_MERGED = 2'd0,
    ST_NEW    = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic        [CNT_BITS-1:0]   cnt;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic ld;
  } cell_ctl_t;

endpackage

// File: hdl/onc_cell.sv
// ----------------------------------------------------------------------------
// onc_cell
// one table slot: rotates to its neighbor during a scan or loads an update
// ----------------------------------------------------------------------------
module onc_cell import onc_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    d_next,
  input  entry_t    d_ld,
  output entry_t    q
);

  entry_t ent_r;

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      ent_r <= d_ld;
    end else if (ctl.shift) begin
      ent_r <= d_next;
    end
  end

  assign q = ent_r;

endmodule

// File: hdl/onc_div.sv
// ----------------------------------------------------------------------------
// onc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module onc_div import onc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             busy,
  output logic [DIV_W-1:0] quo
);

  logic [DIV_W:0]    rem_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DIV_W-1:0]  den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W+1:0]  rem_try;

  assign rem_sh  = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign rem_try = {1'b0, rem_sh} - {2'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CW'(DIV_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (cnt_r != '0) begin
      if (!rem_try[DIV_W+1]) begin
        rem_r <= rem_try[DIV_W:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;

endmodule

// File: hdl/online_nearest_centroid_cluster_core.sv
// ----------------------------------------------------------------------------
// online_nearest_centroid_cluster_core
// online nearest centroid clustering of 3d points with running-mean update
// ----------------------------------------------------------------------------
// One request at a time. The cluster table is a ring of 64 cells that rotates
// once per request past a single squared-distance unit. A request is taken in
// the idle state, the ring is scanned through all 64 cells, and the request is
// then flushed and decided; a merge then runs the bit-serial dividers that form
// the centroid step, and the result is loaded last. The result waits in an
// output register and the core stalls while it is not taken; first_of_set in
// in_tuser empties the table before the point.
module online_nearest_centroid_cluster_core import onc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [REQ_DATA_W-1:0] in_tdata,   // point_x, point_y, point_z
  input  logic [0:0]            in_tuser,   // first_of_set
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [RES_DATA_W-1:0] out_tdata,  // cluster_index, center_x, center_y,
                                            // center_z, member_count, zero pad
  output logic [1:0]            out_tuser,  // status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [MD_BITS-1:0]    cfg_data    // merge_distance
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FLUSH, S_DECIDE, S_DIV, S_FIN
  } state_t;

  localparam int C = COORD_BITS;

  state_t                     state_r;
  logic [MD_BITS-1:0]         md_r;
  logic [2*MD_BITS-1:0]       lim_r;
  logic [USED_W-1:0]          used_r;
  logic [USED_W-1:0]          k_r;
  logic signed [C-1:0]        px_r, py_r, pz_r;

  logic                       s1_valid_r;
  logic [IDX_W-1:0]           s1_idx_r;
  entry_t                     s1_ent_r;
  logic [2*C-1:0]             sqx_r, sqy_r, sqz_r;

  logic                       found_r;
  logic [DIST_W-1:0]          best_d_r;
  logic [IDX_W-1:0]           best_i_r;
  entry_t                     best_ent_r;

  status_t                    kind_r;
  logic [CNT_BITS-1:0]        n_r;
  logic                       negx_r, negy_r, negz_r;
  logic                       div_start;
  logic [DIV_W-1:0]           numx, numy, numz, den;
  logic [DIV_W-1:0]           qx, qy, qz;
  logic                       bx, by, bz;

  entry_t                     cell_q [MAX_CLUSTERS];
  entry_t                     wr_ent;
  logic [IDX_W-1:0]           wr_idx;
  logic                       fin_fire;
  logic                       wr_en;

  status_t                    res_status_r;
  logic [OUT_IDX_W-1:0]       res_idx_r;
  entry_t                     res_ent_r;
  logic                       out_valid_r;

  entry_t                     head;
  logic signed [C:0]          dx, dy, dz;
  logic [C:0]                 ax, ay, az;
  logic [DIST_W-1:0]          dsum;
  logic                       merge;
  logic signed [C:0]          ex, ey, ez;
  logic [C:0]                 mx, my, mz;
  logic [CNT_BITS-1:0]        n_nxt;

  assign head = cell_q[0];
  assign dx = {head.x[C-1], head.x} - {px_r[C-1], px_r};
  assign dy = {head.y[C-1], head.y} - {py_r[C-1], py_r};
  assign dz = {head.z[C-1], head.z} - {pz_r[C-1], pz_r};
  assign ax = dx[C] ? -dx : dx;
  assign ay = dy[C] ? -dy : dy;
  assign az = dz[C] ? -dz : dz;
  assign dsum = DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);
  assign merge = found_r && (best_d_r <= DIST_W'(lim_r));

  // point minus centroid for the step toward the point
  assign ex = {px_r[C-1], px_r} - {best_ent_r.x[C-1], best_ent_r.x};
  assign ey = {py_r[C-1], py_r} - {best_ent_r.y[C-1], best_ent_r.y};
  assign ez = {pz_r[C-1], pz_r} - {best_ent_r.z[C-1], best_ent_r.z};
  assign mx = ex[C] ? -ex : ex;
  assign my = ey[C] ? -ey : ey;
  assign mz = ez[C] ? -ez : ez;
  assign n_nxt = (best_ent_r.cnt == COUNT_MAX) ? COUNT_MAX : best_ent_r.cnt + 1'b1;

  assign div_start = (state_r == S_DECIDE) && merge;
  assign den  = DIV_W'({n_nxt, 1'b0});
  assign numx = DIV_W'({mx[C-1:0], 1'b0}) + DIV_W'(n_nxt);
  assign numy = DIV_W'({my[C-1:0], 1'b0}) + DIV_W'(n_nxt);
  assign numz = DIV_W'({mz[C-1:0], 1'b0}) + DIV_W'(n_nxt);

  onc_div u_div_x (.clk, .rst_n, .start(div_start), .num(numx), .den, .busy(bx), .quo(qx));
  onc_div u_div_y (.clk, .rst_n, .start(div_start), .num(numy), .den, .busy(by), .quo(qy));
  onc_div u_div_z (.clk, .rst_n, .start(div_start), .num(numz), .den, .busy(bz), .quo(qz));

  assign fin_fire = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign wr_en    = fin_fire && (kind_r != ST_FULL);

  always_comb begin
    wr_ent = '0;
    wr_idx = best_i_r;
    if (kind_r == ST_MERGED) begin
      wr_ent.x   = negx_r ? best_ent_r.x - C'(qx) : best_ent_r.x + C'(qx);
      wr_ent.y   = negy_r ? best_ent_r.y - C'(qy) : best_ent_r.y + C'(qy);
      wr_ent.z   = negz_r ? best_ent_r.z - C'(qz) : best_ent_r.z + C'(qz);
      wr_ent.cnt = n_r;
    end else if (kind_r == ST_NEW) begin
      wr_ent.x   = px_r;
      wr_ent.y   = py_r;
      wr_ent.z   = pz_r;
      wr_ent.cnt = CNT_BITS'(1);
      wr_idx     = used_r[IDX_W-1:0];
    end
  end

  for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.shift = (state_r == S_SCAN);
    assign ctl.ld    = wr_en && (wr_idx == IDX_W'(i));
    onc_cell u_cell (
      .clk,
      .ctl,
      .d_next (cell_q[(i + 1) % MAX_CLUSTERS]),
      .d_ld   (wr_ent),
      .q      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      md_r        <= MD_RESET;
      used_r      <= '0;
      k_r         <= '0;
      s1_valid_r  <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      kind_r      <= ST_NEW;
    end else begin
      if (cfg_valid) begin
        md_r <= cfg_data;
      end
      if (out_valid_r && out_tready && !fin_fire) begin
        out_valid_r <= 1'b0;
      end
      s1_valid_r <= (state_r == S_SCAN) && (k_r < used_r);
      if (s1_valid_r && (!found_r || dsum < best_d_r)) begin
        found_r    <= 1'b1;
        best_d_r   <= dsum;
        best_i_r   <= s1_idx_r;
        best_ent_r <= s1_ent_r;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            px_r    <= in_tdata[C-1:0];
            py_r    <= in_tdata[2*C-1:C];
            pz_r    <= in_tdata[3*C-1:2*C];
            k_r     <= '0;
            found_r <= 1'b0;
            if (in_tuser[0]) begin
              used_r <= '0;
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          k_r <= k_r + 1'b1;
          if (k_r == USED_W'(MAX_CLUSTERS - 1)) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          n_r    <= n_nxt;
          negx_r <= ex[C];
          negy_r <= ey[C];
          negz_r <= ez[C];
          if (merge) begin
            kind_r  <= ST_MERGED;
            state_r <= S_DIV;
          end else begin
            kind_r  <= (used_r == USED_W'(MAX_CLUSTERS)) ? ST_FULL : ST_NEW;
            state_r <= S_FIN;
          end
        end
        S_DIV: begin
          if (!bx && !by && !bz) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            out_valid_r  <= 1'b1;
            res_status_r <= kind_r;
            if (kind_r == ST_FULL) begin
              res_idx_r <= '0;
              res_ent_r <= '0;
            end else begin
              res_idx_r <= OUT_IDX_W'(wr_idx);
              res_ent_r <= wr_ent;
            end
            if (kind_r == ST_NEW) begin
              used_r <= used_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim_r    <= md_r * md_r;
    s1_idx_r <= k_r[IDX_W-1:0];
    s1_ent_r <= head;
    sqx_r    <= ax[C-1:0] * ax[C-1:0];
    sqy_r    <= ay[C-1:0] * ay[C-1:0];
    sqz_r    <= az[C-1:0] * az[C-1:0];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_status_r;
  assign out_tdata  = RES_DATA_W'({res_ent_r.cnt, res_ent_r.z, res_ent_r.y,
                                   res_ent_r.x, res_idx_r});

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(MAX_CLUSTERS))
    else $error("cluster count beyond table size");

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while busy");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_status_r == ST_FULL) |-> (res_ent_r.cnt == '0))
    else $error("dropped point reports a count");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_status_r != ST_FULL) |-> (res_ent_r.cnt != '0))
    else $error("assigned cluster has zero count");

endmodule

// File: dv/online_nearest_centroid_cluster_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// online_nearest_centroid_cluster_core_tb
// drives points through the clustering core, tracks the cluster table in a
// scoreboard and compares every assignment result field by field
// ----------------------------------------------------------------------------
module online_nearest_centroid_cluster_core_tb;
  import onc_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic [OUT_IDX_W-1:0] idx;
    status_t              st;
    coord_t               cx, cy, cz;
    logic [CNT_BITS-1:0]  cnt;
  } assign_t;

  int errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  class cluster_scoreboard;
    longint  cx[MAX_CLUSTERS], cy[MAX_CLUSTERS], cz[MAX_CLUSTERS];
    int      cnt[MAX_CLUSTERS];
    int      used = 0;
    int      fuse_limit = 256;
    assign_t pending[$];
    int      n_merged = 0, n_new = 0, n_full = 0;

    function automatic longint step_toward(longint c, longint p, int n);
      longint d, m, q;
      d = p - c;
      m = d < 0 ? -d : d;
      q = (2 * m + n) / (2 * longint'(n));
      return d < 0 ? c - q : c + q;
    endfunction

    function automatic longint sqr(longint d);
      return d * d;
    endfunction

    function void note_point(coord_t px, coord_t py, coord_t pz, bit first);
      assign_t r;
      longint  bd, d, lim;
      int      best;
      bit      found;
      found = 0; best = 0; bd = 0;
      lim = longint'(fuse_limit) * fuse_limit;
      if (first) used = 0;
      for (int i = 0; i < used; i++) begin
        d = sqr(cx[i] - px) + sqr(cy[i] - py) + sqr(cz[i] - pz);
        if (!found || d < bd) begin
          bd = d; best = i; found = 1;
        end
      end
      if (found && bd <= lim) begin
        if (cnt[best] < 65535) cnt[best]++;
        cx[best] = step_toward(cx[best], px, cnt[best]);
        cy[best] = step_toward(cy[best], py, cnt[best]);
        cz[best] = step_toward(cz[best], pz, cnt[best]);
        r.st = ST_MERGED;
      end else if (used < MAX_CLUSTERS) begin
        best = used;
        cx[best] = px; cy[best] = py; cz[best] = pz; cnt[best] = 1;
        used++;
        r.st = ST_NEW;
      end else begin
        r = '{idx: 0, st: ST_FULL, cx: 0, cy: 0, cz: 0, cnt: 0};
        pending = {pending, r};
        return;
      end
      r.idx = best[OUT_IDX_W-1:0];
      r.cx = coord_t'(cx[best]); r.cy = coord_t'(cy[best]); r.cz = coord_t'(cz[best]);
      r.cnt = cnt[best][CNT_BITS-1:0];
      pending = {pending, r};
    endfunction

    task check_result(logic [RES_DATA_W-1:0] d, logic [1:0] u);
      assign_t w;
      if (pending.size() == 0) begin
        report("result without request", 1, 0);
        return;
      end
      w = pending.pop_front();
      case (w.st)
        ST_MERGED: n_merged++;
        ST_NEW:    n_new++;
        default:   n_full++;
      endcase
      if (u != w.st) report("status", u, w.st);
      if (d[5:0] != w.idx) report("cluster_index", d[5:0], w.idx);
      if (d[21:6] != w.cx) report("center_x", coord_t'(d[21:6]), w.cx);
      if (d[37:22] != w.cy) report("center_y", coord_t'(d[37:22]), w.cy);
      if (d[53:38] != w.cz) report("center_z", coord_t'(d[53:38]), w.cz);
      if (d[69:54] != w.cnt) report("member_count", d[69:54], w.cnt);
      if (d[RES_DATA_W-1:70] != 0) report("pad", d[RES_DATA_W-1:70], 0);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_valid = 0;
  logic [REQ_DATA_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic [MD_BITS-1:0] cfg_data = '0;
  logic in_tready, out_tvalid, cfg_ready;
  logic [RES_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  cluster_scoreboard sb = new();
  int send_idle = 0, recv_idle = 0;

  online_nearest_centroid_cluster_core uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL online_nearest_centroid_cluster_core");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_point(input coord_t px, py, pz, input bit first);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_tvalid <= 1;
    in_tdata <= {pz, py, px};
    in_tuser <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_point(px, py, pz, first);
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  task automatic set_merge_distance(input int v);
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= MD_BITS'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.fuse_limit = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic coord_t near(coord_t c, int spread);
    return coord_t'(int'(c) + $urandom_range(2 * spread) - spread);
  endfunction

  task automatic random_phase(input int items);
    coord_t bx, by, bz;
    int k;
    bx = 0; by = 0; bz = 0;
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(99);
      if (k < 15) begin
        bx = coord_t'($urandom); by = coord_t'($urandom); bz = coord_t'($urandom);
      end
      if (k < 3) send_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 1);
      else if (k < 20)
        send_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 0);
      else send_point(near(bx, 300), near(by, 300), near(bz, 300), 0);
    end
  endtask

  initial begin
    int guard;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // extremes, empty table, ties and table full
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1);
    send_point(-16'sh8000, -16'sh8000, -16'sh8000, 0);
    send_point(16'sh7f00, 16'sh7fff, 16'sh7fff, 0);
    send_point(0, 0, 0, 1);
    send_point(256, 0, 0, 0);
    send_point(128, 0, 0, 0);
    send_point(-1, 0, 0, 0);
    send_point(-3, 1, 1, 0);
    for (int i = 0; i < 66; i++) send_point(coord_t'(i * 1000 - 32000), 5, -5, i == 0);
    set_merge_distance(0);
    send_point(0, 0, 0, 1);
    send_point(0, 0, 0, 0);
    send_point(1, 0, 0, 0);
    set_merge_distance(65535);
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1);
    send_point(-16'sh8000, -16'sh8000, -16'sh8000, 0);
    send_point(-16'sh8000, 16'sh7fff, 0, 0);

    set_merge_distance(600);
    send_idle = 32; recv_idle = 79;
    random_phase(356);
    set_merge_distance($urandom_range(65535));
    send_idle = 79; recv_idle = 32;
    random_phase(356);
    set_merge_distance(1 + $urandom_range(2000));
    send_idle = 0; recv_idle = 0;
    random_phase(362);

    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
    if (sb.pending.size() != 0) begin
      report("results never arrived", sb.pending.size(), 0);
    end
    $display("points covered: %0d merged, %0d new clusters, %0d dropped on full table",
             sb.n_merged, sb.n_new, sb.n_full);
    if (errors == 0) $display("PASS online_nearest_centroid_cluster_core");
    else $display("FAIL online_nearest_centroid_cluster_core");
    $finish;
  end
endmodule
